// ===== hdl/smvm_pkg.sv =====
// Shared types and constants for the sparse matrix vector multiply block.
// Holds item command codes, field widths and the row result structure.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package smvm_pkg;

    localparam int CMD_W     = 2;
    localparam int COL_W     = 10;
    localparam int VAL_W     = 32;
    localparam int SUM_W     = 64;
    localparam int ROW_W     = 16;

    localparam int DEFAULT_VECTOR_DEPTH = 1024;

    localparam logic [CMD_W-1:0] CMD_LOAD      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACC       = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ACC_CLOSE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLOSE     = 2'd3;

    localparam logic signed [SUM_W-1:0] ACC_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] ACC_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic                    saturated;
        logic [ROW_W-1:0]        row_number;
        logic signed [SUM_W-1:0] row_sum;
    } t_row_result;

    typedef struct packed {
        logic step;
        logic close;
    } t_acc_ctl;

endpackage

`default_nettype wire

// ===== hdl/smvm_vstore.sv =====
// Dense vector store: one synchronous memory with one write and one read port.
// Read data is registered and held while the read enable is low.
// Depends on smvm_pkg for the element width.
`timescale 1ns / 1ps
`default_nettype none

module smvm_vstore #(
    parameter int VECTOR_DEPTH = smvm_pkg::DEFAULT_VECTOR_DEPTH,
    parameter int ADDR_W       = $clog2(VECTOR_DEPTH)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_wr_en,
    input  wire logic [ADDR_W-1:0]              i_wr_addr,
    input  wire logic [smvm_pkg::VAL_W-1:0]     i_wr_data,
    input  wire logic                           i_rd_en,
    input  wire logic [ADDR_W-1:0]              i_rd_addr,
    output logic      [smvm_pkg::VAL_W-1:0]     o_rd_data
);

    logic [smvm_pkg::VAL_W-1:0] r_mem [VECTOR_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/smvm_sat_acc.sv =====
// Saturating Q32.32 row accumulator with row counter and saturation flag.
// Adds one product term per step and hands out the row result on close.
// Depends on smvm_pkg for widths, limits and the result structure.
`timescale 1ns / 1ps
`default_nettype none

module smvm_sat_acc (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire smvm_pkg::t_acc_ctl                i_ctl,
    input  wire logic signed [smvm_pkg::SUM_W-1:0] i_term,
    output smvm_pkg::t_row_result                  o_result
);

    logic signed [smvm_pkg::SUM_W-1:0] r_acc;
    logic [smvm_pkg::ROW_W-1:0]        r_row;
    logic                              r_ovf;

    logic signed [smvm_pkg::SUM_W:0]   sum_wide;
    logic                              ovf_now;
    logic signed [smvm_pkg::SUM_W-1:0] sat_sum;

    always_comb begin
        sum_wide = {r_acc[smvm_pkg::SUM_W-1], r_acc} + {i_term[smvm_pkg::SUM_W-1], i_term};
        ovf_now  = sum_wide[smvm_pkg::SUM_W] ^ sum_wide[smvm_pkg::SUM_W-1];
        if (ovf_now) begin
            sat_sum = sum_wide[smvm_pkg::SUM_W] ? smvm_pkg::ACC_MIN : smvm_pkg::ACC_MAX;
        end else begin
            sat_sum = sum_wide[smvm_pkg::SUM_W-1:0];
        end
        o_result.row_sum    = sat_sum;
        o_result.row_number = r_row;
        o_result.saturated  = r_ovf | ovf_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_row <= '0;
            r_ovf <= 1'b0;
        end else if (i_ctl.step) begin
            if (i_ctl.close) begin
                r_acc <= '0;
                r_ovf <= 1'b0;
                r_row <= r_row + 1'b1;
            end else begin
                r_acc <= sat_sum;
                r_ovf <= r_ovf | ovf_now;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sparse_matrix_vector_multiply.sv =====
// Top level of the CSR sparse matrix times dense vector block, y = A*x.
// Depends on smvm_pkg, smvm_vstore and smvm_sat_acc.
//
// Channel  Direction  tuser           tdata (lowest bit first)
// s_axis   in         cmd[1:0]        column[9:0], value[41:10], zero pad[47:42]
// m_axis   out        saturated[0]    row_sum[63:0], row_number[79:64]
//
// One item is taken per cycle while no closing item is held by output back-pressure;
// the vector store read, the multiplier and the saturating add each own one register
// stage, and a row result reaches the output register through them in that order.
// Synchronous active-low reset clears the pipeline, the accumulator, the row
// counter and the flag; the vector store is not cleared and must be loaded.
// Stages advance into empty slots, so non-closing items keep flowing while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module sparse_matrix_vector_multiply #(
    parameter int VECTOR_DEPTH = smvm_pkg::DEFAULT_VECTOR_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [47:0] i_s_axis_tdata,   // column[9:0], value[41:10], zeros
    input  wire logic [1:0]  i_s_axis_tuser,   // cmd[1:0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [79:0]      o_m_axis_tdata,   // row_sum[63:0], row_number[79:64]
    output logic [0:0]       o_m_axis_tuser    // saturated[0]
);

    localparam int ADDR_W = $clog2(VECTOR_DEPTH);
    localparam int EXT_W  = (ADDR_W > smvm_pkg::COL_W) ? ADDR_W : smvm_pkg::COL_W;

    logic [smvm_pkg::CMD_W-1:0]        in_cmd;
    logic [smvm_pkg::COL_W-1:0]        in_col;
    logic signed [smvm_pkg::VAL_W-1:0] in_val;
    logic [EXT_W-1:0]                  col_ext;
    logic [ADDR_W-1:0]                 addr;
    logic                              in_range;
    logic                              accept;
    logic                              is_acc;
    logic                              is_close;

    logic                              r_v1;
    logic                              r_close1;
    logic                              r_use1;
    logic signed [smvm_pkg::VAL_W-1:0] r_val1;
    logic [smvm_pkg::VAL_W-1:0]        rd_data;
    logic signed [smvm_pkg::VAL_W-1:0] x1;

    logic                              r_v2;
    logic                              r_close2;
    logic signed [smvm_pkg::SUM_W-1:0] r_prod2;

    logic                              r_out_v;
    smvm_pkg::t_row_result             r_out;

    logic                              out_free;
    logic                              consume2;
    logic                              en2;
    logic                              en1;
    smvm_pkg::t_acc_ctl                acc_ctl;
    smvm_pkg::t_row_result             acc_result;

    assign in_cmd   = i_s_axis_tuser;
    assign in_col   = i_s_axis_tdata[9:0];
    assign in_val   = i_s_axis_tdata[41:10];
    assign col_ext  = EXT_W'(in_col);
    assign addr     = col_ext[ADDR_W-1:0];
    assign in_range = (32'(in_col) < 32'(VECTOR_DEPTH));

    assign is_acc   = (in_cmd == smvm_pkg::CMD_ACC) || (in_cmd == smvm_pkg::CMD_ACC_CLOSE);
    assign is_close = (in_cmd == smvm_pkg::CMD_ACC_CLOSE) || (in_cmd == smvm_pkg::CMD_CLOSE);

    assign out_free = !r_out_v || i_m_axis_tready;
    assign consume2 = r_v2 && (!r_close2 || out_free);
    assign en2      = !r_v2 || consume2;
    assign en1      = !r_v1 || en2;

    assign o_s_axis_tready = en1;
    assign accept          = i_s_axis_tvalid && en1;

    smvm_vstore #(
        .VECTOR_DEPTH (VECTOR_DEPTH),
        .ADDR_W       (ADDR_W)
    ) u_vstore (
        .i_clk     (i_clk),
        .i_wr_en   (accept && (in_cmd == smvm_pkg::CMD_LOAD) && in_range),
        .i_wr_addr (addr),
        .i_wr_data (in_val),
        .i_rd_en   (en1),
        .i_rd_addr (addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= accept && (in_cmd != smvm_pkg::CMD_LOAD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_close1 <= is_close;
            r_use1   <= is_acc && in_range;
            r_val1   <= in_val;
        end
    end

    assign x1 = r_use1 ? $signed(rd_data) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_close2 <= r_close1;
            r_prod2  <= smvm_pkg::SUM_W'(r_val1 * x1);
        end
    end

    assign acc_ctl.step  = consume2;
    assign acc_ctl.close = r_close2;

    smvm_sat_acc u_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (acc_ctl),
        .i_term   (r_prod2),
        .o_result (acc_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_free) begin
            r_out_v <= consume2 && r_close2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && consume2 && r_close2) begin
            r_out <= acc_result;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {r_out.row_number, r_out.row_sum};
    assign o_m_axis_tuser  = r_out.saturated;

endmodule

`default_nettype wire

// ===== test/tb_sparse_matrix_vector_multiply.sv =====
// Self-checking testbench for sparse_matrix_vector_multiply: loads the vector, streams rows
// of nonzeros and checks each row sum, row number and saturation flag against a local model.
// Depends on smvm_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_sparse_matrix_vector_multiply;

    localparam int VDEPTH = smvm_pkg::DEFAULT_VECTOR_DEPTH;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int PIPE_DRAIN = 8;
    localparam logic signed [smvm_pkg::VAL_W-1:0] Q_ONE = 32'sh0001_0000;
    localparam logic signed [smvm_pkg::VAL_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [smvm_pkg::VAL_W-1:0] Q_MIN = 32'sh8000_0000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [47:0] s_data = '0;
    logic [1:0]  s_user = '0;
    logic        m_ready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [79:0] o_m_axis_tdata;
    logic [0:0]  o_m_axis_tuser;

    sparse_matrix_vector_multiply #(
        .VECTOR_DEPTH(VDEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_data),
        .i_s_axis_tuser (s_user),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    // Local copy of the block's state.
    logic signed [smvm_pkg::VAL_W-1:0] vec_mem [VDEPTH];
    logic signed [smvm_pkg::SUM_W-1:0] acc_sum = '0;
    logic [smvm_pkg::ROW_W-1:0]        next_row = '0;
    logic                              acc_clamped = 1'b0;
    int                                loaded_cols [$];
    bit                                col_loaded [VDEPTH];

    smvm_pkg::t_row_result expected_rows [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asks = 0;
    int items_sent = 0;
    int rows_checked = 0;
    int sat_rows = 0;
    int mismatches = 0;
    int idle_cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void model_item(logic [smvm_pkg::CMD_W-1:0] cmd,
                                       logic [smvm_pkg::COL_W-1:0] col,
                                       logic signed [smvm_pkg::VAL_W-1:0] val);
        logic signed [smvm_pkg::SUM_W-1:0] elem_x;
        logic signed [smvm_pkg::SUM_W-1:0] term;
        logic signed [smvm_pkg::SUM_W:0]   wide;
        smvm_pkg::t_row_result             row;
        if (cmd == smvm_pkg::CMD_LOAD) begin
            if (col < VDEPTH) vec_mem[col] = val;
            return;
        end
        if (cmd == smvm_pkg::CMD_ACC || cmd == smvm_pkg::CMD_ACC_CLOSE) begin
            elem_x = (col < VDEPTH) ? smvm_pkg::SUM_W'(vec_mem[col]) : '0;
            term = smvm_pkg::SUM_W'(val) * elem_x;
            wide = (smvm_pkg::SUM_W+1)'(acc_sum) + (smvm_pkg::SUM_W+1)'(term);
            if (wide[smvm_pkg::SUM_W] != wide[smvm_pkg::SUM_W-1]) begin
                acc_sum = wide[smvm_pkg::SUM_W] ? smvm_pkg::ACC_MIN : smvm_pkg::ACC_MAX;
                acc_clamped = 1'b1;
            end else begin
                acc_sum = wide[smvm_pkg::SUM_W-1:0];
            end
        end
        if (cmd == smvm_pkg::CMD_ACC) return;
        row.row_sum = acc_sum;
        row.row_number = next_row;
        row.saturated = acc_clamped;
        expected_rows.push_back(row);
        acc_sum = '0;
        acc_clamped = 1'b0;
        next_row = next_row + 1'b1;
    endfunction

    // Called just after a falling edge; returns just after the falling edge that follows
    // acceptance, with valid still high.
    task automatic send_item(logic [smvm_pkg::CMD_W-1:0] cmd,
                             logic [smvm_pkg::COL_W-1:0] col,
                             logic signed [smvm_pkg::VAL_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_user <= cmd;
        s_data <= {6'b0, val, col};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        model_item(cmd, col, val);
        if (cmd == smvm_pkg::CMD_LOAD && !col_loaded[col]) begin
            col_loaded[col] = 1'b1;
            loaded_cols.push_back(int'(col));
        end
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic signed [smvm_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return Q_MIN;
            1: return Q_MAX;
            2, 3, 4, 5: return $urandom;
            default: return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
        endcase
    endfunction

    function automatic logic [smvm_pkg::COL_W-1:0] loaded_col();
        return smvm_pkg::COL_W'(loaded_cols[$urandom_range(loaded_cols.size()-1)]);
    endfunction

    task automatic test_directed();
        send_item(smvm_pkg::CMD_LOAD, 10'd0, Q_MIN);
        send_item(smvm_pkg::CMD_LOAD, 10'd1023, Q_MAX);
        send_item(smvm_pkg::CMD_LOAD, 10'h2AA, Q_ONE);
        send_item(smvm_pkg::CMD_LOAD, 10'h155, -Q_ONE);
        // A row with no nonzeros gives zero.
        send_item(smvm_pkg::CMD_CLOSE, 10'd0, '0);
        send_item(smvm_pkg::CMD_ACC, 10'h2AA, Q_ONE);
        send_item(smvm_pkg::CMD_ACC_CLOSE, 10'h155, 32'sh0002_0000);
        // Positive clamp, then a further positive term on the clamped sum.
        send_item(smvm_pkg::CMD_ACC, 10'd0, Q_MIN);
        send_item(smvm_pkg::CMD_ACC, 10'd0, Q_MIN);
        send_item(smvm_pkg::CMD_ACC_CLOSE, 10'd1023, Q_ONE);
        // Negative clamp, a further negative term, then a positive term that pulls the sum back.
        repeat (3) send_item(smvm_pkg::CMD_ACC, 10'd1023, Q_MIN);
        send_item(smvm_pkg::CMD_ACC, 10'd0, Q_MAX);
        send_item(smvm_pkg::CMD_ACC, 10'd0, Q_MIN);
        send_item(smvm_pkg::CMD_CLOSE, 10'd1023, Q_MAX);
        // Overwritten element, and a row after saturation starts clean.
        send_item(smvm_pkg::CMD_LOAD, 10'h2AA, 32'sh0000_8000);
        send_item(smvm_pkg::CMD_ACC_CLOSE, 10'h2AA, Q_MAX);
        send_item(smvm_pkg::CMD_ACC, 10'd1023, Q_MAX);
        send_item(smvm_pkg::CMD_ACC, 10'd1023, '0);
        send_item(smvm_pkg::CMD_ACC_CLOSE, 10'd0, '0);
    endtask

    task automatic test_random_rows(int n_items);
        int start;
        int pick;
        int nnz;
        start = items_sent;
        while (items_sent - start < n_items) begin
            pick = $urandom_range(99);
            if (pick < 15 || loaded_cols.size() == 0) begin
                send_item(smvm_pkg::CMD_LOAD, smvm_pkg::COL_W'($urandom_range(VDEPTH-1)),
                          pick_value());
            end else if (pick < 20) begin
                send_item(smvm_pkg::CMD_CLOSE, smvm_pkg::COL_W'($urandom), $urandom);
            end else begin
                nnz = $urandom_range(1, 8);
                repeat (nnz - 1)
                    send_item(smvm_pkg::CMD_ACC, loaded_col(), pick_value());
                if ($urandom_range(1)) begin
                    send_item(smvm_pkg::CMD_ACC_CLOSE, loaded_col(), pick_value());
                end else begin
                    send_item(smvm_pkg::CMD_ACC, loaded_col(), pick_value());
                    send_item(smvm_pkg::CMD_CLOSE, smvm_pkg::COL_W'($urandom), $urandom);
                end
            end
        end
    endtask

    task automatic test_output_backpressure();
        hold_asks++;
        test_random_rows(60);
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 12;
        recv_idle_pct = 83;
        test_directed();
        test_random_rows(170);

        send_idle_pct = 83;
        recv_idle_pct = 12;
        test_random_rows(170);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_rows(170);
        test_output_backpressure();
        s_valid <= 1'b0;

        while (expected_rows.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
        $display("Sent %0d items, checked %0d row results, %0d of them saturated.",
                 items_sent, rows_checked, sat_rows);
        $display("Covered three idle mixes, clamped rows and a long output hold-off.");
        if (mismatches == 0) begin
            $display("[sparse_matrix_vector_multiply] OK");
        end else begin
            $display("%0d mismatches.", mismatches);
            $display("[sparse_matrix_vector_multiply] ERROR");
        end
        $finish;
    end

    initial begin
        int hold_done;
        int hold_left;
        hold_done = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_asks != hold_done) begin
                hold_done = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        smvm_pkg::t_row_result got;
        smvm_pkg::t_row_result want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            got = {o_m_axis_tuser[0], o_m_axis_tdata[79:64], o_m_axis_tdata[63:0]};
            if (expected_rows.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected row result: sum %h row %0d sat %b",
                             got.row_sum, got.row_number, got.saturated);
            end else begin
                want = expected_rows.pop_front();
                rows_checked++;
                if (want.saturated) sat_rows++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Row mismatch: expected sum %h row %0d sat %b, ",
                                  "got sum %h row %0d sat %b"},
                                 want.row_sum, want.row_number, want.saturated,
                                 got.row_sum, got.row_number, got.saturated);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles.", STALL_LIMIT);
            $display("[sparse_matrix_vector_multiply] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== files.f =====
hdl/smvm_pkg.sv
hdl/smvm_vstore.sv
hdl/smvm_sat_acc.sv
hdl/sparse_matrix_vector_multiply.sv
test/tb_sparse_matrix_vector_multiply.sv
